// ===== hdl/assert_macros.svh =====
// assertion macros shared by the vertical depthwise convolution rtl
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VDC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define VDC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define VDC_ASSERT(lbl, clk, rst_n, prop)
`define VDC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/vdc_pkg.sv =====
// shared types, constants and helpers for the vertical depthwise convolution
// no dependencies
`timescale 1ns / 1ps

package vdc_pkg;

  localparam int MAX_TAPS_DEF   = 8;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_TAP_W = 4;
  localparam int CFG_DIM_W = 11;
  localparam int WORD_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 36;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HI   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_VALUE   = 3'd5;

  typedef struct packed {
    logic [CFG_TAP_W-1:0]       tap_count;
    logic [CFG_DIM_W-1:0]       image_width;
    logic [CFG_DIM_W-1:0]       image_height;
    logic [WORD_W-1:0]          weights_lo;
    logic [WORD_W-1:0]          weights_hi;
    logic signed [SAMPLE_W-1:0] bias_value;
  } vdc_cfg_t;

  typedef struct packed {
    logic capture;
    logic issue;
    logic store;
    logic load_out;
  } vdc_cmd_t;

  typedef struct packed {
    logic produce;
    logic tap_last;
    logic pipe_empty;
    logic out_free;
  } vdc_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_STORE
  } vdc_state_t;

  function automatic logic signed [SAMPLE_W-1:0] weight_sel(
    input logic [2:0]        k,
    input logic [WORD_W-1:0] w_lo,
    input logic [WORD_W-1:0] w_hi
  );
    logic [WORD_W-1:0] word;
    word = k[2] ? w_hi : w_lo;
    case (k[1:0])
      2'd0:    weight_sel = word[15:0];
      2'd1:    weight_sel = word[31:16];
      2'd2:    weight_sel = word[47:32];
      default: weight_sel = word[63:48];
    endcase
  endfunction

endpackage

// ===== hdl/vdc_regs.sv =====
// configuration register file of the vertical depthwise convolution
// depends on vdc_pkg
`timescale 1ns / 1ps

module vdc_regs import vdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output vdc_cfg_t             cfg
);

  vdc_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_count    <= CFG_TAP_W'(1);
      cfg_r.image_width  <= CFG_DIM_W'(1024);
      cfg_r.image_height <= CFG_DIM_W'(1024);
      cfg_r.weights_lo   <= '0;
      cfg_r.weights_hi   <= '0;
      cfg_r.bias_value   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TAP_COUNT:    cfg_r.tap_count    <= cfg_data[CFG_TAP_W-1:0];
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[CFG_DIM_W-1:0];
        REG_WEIGHTS_LO:   cfg_r.weights_lo   <= cfg_data;
        REG_WEIGHTS_HI:   cfg_r.weights_hi   <= cfg_data;
        REG_BIAS_VALUE:   cfg_r.bias_value   <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/vdc_ctrl.sv =====
// sequencer for the vertical depthwise convolution: accept, tap walk, drain, store
// depends on vdc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vdc_ctrl import vdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  vdc_status_t status,
  output vdc_cmd_t    cmd
);

  vdc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = status.produce ? ST_MAC : ST_STORE;
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (status.tap_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        if (!status.produce || status.out_free) begin
          cmd.store    = 1'b1;
          cmd.load_out = status.produce;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `VDC_ASSERT(a_skip_to_store, clk, rst_n, (cmd.capture && !status.produce) |=> (state_r == ST_STORE))
  `VDC_ASSERT(a_store_after_drain, clk, rst_n, cmd.store |-> status.pipe_empty)
  `VDC_ASSERT_NEVER(a_load_when_full, clk, rst_n, cmd.load_out && !status.out_free)

endmodule

// ===== hdl/vdc_dpath.sv =====
// datapath: line store, position counters, shared multiply-accumulate, output register
// depends on vdc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vdc_dpath import vdc_pkg::*; #(
  parameter int MAX_TAPS   = MAX_TAPS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vdc_cfg_t                   cfg,
  input  vdc_cmd_t                   cmd,
  output vdc_status_t                status,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_result_value,
  output logic                       out_last_of_plane
);

  localparam int HIST_ROWS = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int TAP_W = $clog2(MAX_TAPS + 1);
  localparam int KW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SW    = (HIST_ROWS > 1) ? $clog2(HIST_ROWS) : 1;
  localparam int CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW   = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ? $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
  localparam int RCW   = ($clog2(MAX_HEIGHT + 1) > CFG_DIM_W) ? $clog2(MAX_HEIGHT + 1) : CFG_DIM_W;
  localparam int MEM_D = HIST_ROWS * (1 << CB);
  localparam int AW    = $clog2(MEM_D);
  localparam logic signed [ACC_W:0] SAT_HI = 32767;
  localparam logic signed [ACC_W:0] SAT_LO = -32768;

  logic [SAMPLE_W-1:0] mem [MEM_D];

  logic [CB-1:0] col_r;
  logic [RB-1:0] row_r;
  logic [SW-1:0] slot_r;
  logic [KW-1:0] k_r;
  logic          p1_v_r, p2_v_r;
  logic          out_valid_r;

  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic signed [SAMPLE_W-1:0] p1_w_r;
  logic                       p1_sel_x_r;
  logic signed [31:0]         prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [SAMPLE_W-1:0] res_r;
  logic                       last_r;

  logic [TAP_W-1:0] taps_c;
  logic [WCW-1:0]   width_c;
  logic [RCW-1:0]   height_c;
  logic             col_last, row_last, produce;
  logic [KW-1:0]    tap_dist;
  logic [KW:0]      slot_sum;
  logic [SW-1:0]    rd_slot;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic signed [SAMPLE_W-1:0] mul_in;
  logic signed [ACC_W:0]      rnd;
  logic signed [ACC_W:0]      shifted;
  logic signed [SAMPLE_W-1:0] sat_val;

  always_comb begin
    if (cfg.tap_count == '0) begin
      taps_c = TAP_W'(1);
    end else if (cfg.tap_count > CFG_TAP_W'(MAX_TAPS)) begin
      taps_c = TAP_W'(MAX_TAPS);
    end else begin
      taps_c = TAP_W'(cfg.tap_count);
    end
    if (cfg.image_width == '0) begin
      width_c = WCW'(1);
    end else if (WCW'(cfg.image_width) > WCW'(MAX_WIDTH)) begin
      width_c = WCW'(MAX_WIDTH);
    end else begin
      width_c = WCW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      height_c = RCW'(1);
    end else if (RCW'(cfg.image_height) > RCW'(MAX_HEIGHT)) begin
      height_c = RCW'(MAX_HEIGHT);
    end else begin
      height_c = RCW'(cfg.image_height);
    end
  end

  assign col_last = (WCW'(col_r) + WCW'(1)) >= width_c;
  assign row_last = (RCW'(row_r) + RCW'(1)) >= height_c;
  assign produce  = (RCW'(row_r) + RCW'(1)) >= RCW'(taps_c);

  // rows above the current one for this tap, and the slot holding that row
  assign tap_dist = KW'(taps_c - TAP_W'(1)) - k_r;
  assign slot_sum = (KW+1)'(slot_r) + (KW+1)'(HIST_ROWS) - (KW+1)'(tap_dist);
  assign rd_slot  = (slot_sum >= (KW+1)'(HIST_ROWS)) ?
                    SW'(slot_sum - (KW+1)'(HIST_ROWS)) : SW'(slot_sum);
  assign rd_addr  = AW'({rd_slot, col_r});
  assign wr_addr  = AW'({slot_r, col_r});

  assign mul_in = p1_sel_x_r ? x_r : rd_r;

  // round half up by 8 bits, then saturate
  assign rnd     = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(128);
  assign shifted = rnd >>> 8;
  always_comb begin
    if (shifted > SAT_HI) begin
      sat_val = SAMPLE_W'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      sat_val = SAMPLE_W'(SAT_LO);
    end else begin
      sat_val = SAMPLE_W'(shifted);
    end
  end

  assign status.produce    = produce;
  assign status.tap_last   = (TAP_W'(k_r) == (taps_c - TAP_W'(1)));
  assign status.pipe_empty = !p1_v_r && !p2_v_r;
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_result_value  = res_r;
  assign out_last_of_plane = last_r;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_r <= mem[rd_addr];
    end
    if (cmd.store) begin
      mem[wr_addr] <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      slot_r      <= '0;
      k_r         <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.issue;
      p2_v_r <= p1_v_r;
      if (cmd.capture) begin
        k_r <= '0;
      end else if (cmd.issue) begin
        k_r <= k_r + KW'(1);
      end
      if (cmd.store) begin
        if (col_last) begin
          col_r <= '0;
          if (row_last) begin
            row_r  <= '0;
            slot_r <= '0;
          end else begin
            row_r  <= row_r + RB'(1);
            slot_r <= (slot_r == SW'(HIST_ROWS - 1)) ? '0 : slot_r + SW'(1);
          end
        end else begin
          col_r <= col_r + CB'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r   <= in_sample;
      acc_r <= {{(ACC_W-SAMPLE_W-8){cfg.bias_value[SAMPLE_W-1]}}, cfg.bias_value, 8'h00};
    end else if (p2_v_r) begin
      acc_r <= acc_r + {{(ACC_W-32){prod_r[31]}}, prod_r};
    end
    if (cmd.issue) begin
      p1_w_r     <= weight_sel(3'(k_r), cfg.weights_lo, cfg.weights_hi);
      p1_sel_x_r <= (tap_dist == '0);
    end
    if (p1_v_r) begin
      prod_r <= p1_w_r * mul_in;
    end
    if (cmd.load_out) begin
      res_r  <= sat_val;
      last_r <= col_last && row_last;
    end
  end

  `VDC_ASSERT(a_slot_range, clk, rst_n, 1'b1 |-> ((KW+1)'(slot_r) < (KW+1)'(HIST_ROWS)))
  `VDC_ASSERT(a_tap_in_range, clk, rst_n, cmd.issue |-> (TAP_W'(k_r) < taps_c))
  `VDC_ASSERT(a_plane_wrap, clk, rst_n, (cmd.load_out && col_last && row_last) |=> ((col_r == '0) && (row_r == '0)))

endmodule

// ===== hdl/vertical_depthwise_conv_forward_top.sv =====
// Vertical depthwise convolution, one plane at a time, valid region only.
// Channels: in_ (sample beats in raster order, valid/stall), out_ (result
// beats valid/stall, result_value and last_of_plane), cfg_ (register
// writes, valid/ready, index 0..5 as tap_count, image_width, image_height,
// weights_first_four, weights_last_four, bias_value; cfg_ready is always high).
// A sample beat in a row at or below tap_count-1 yields one result beat;
// earlier rows only fill the line store. Q8.8 math: bias and products summed,
// rounded half up by 8 bits, saturated to 16 bits.
// Steps: the sample beat is captured, the taps are issued in turn to the
// shared multiply-accumulate, its pipeline drains, and the store step
// writes the line store and loads the output register; a sample with no
// result goes from capture straight to store. The next sample is taken only
// after the store, since a single multiply-accumulate reads one row per tap.
// The line store is not cleared; entries are written before they are read
// within a plane. Reset clears positions, tap index and valid flags, not data.
// While out_stall holds, the finished result waits in the output register and
// one more sample may be processed up to its store step; in_stall stays high
// until the output register frees.
// depends on vdc_pkg, vdc_regs, vdc_ctrl, vdc_dpath
`timescale 1ns / 1ps

module vertical_depthwise_conv_forward_top import vdc_pkg::*; #(
  parameter int MAX_TAPS   = MAX_TAPS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_result_value,
  output logic                       out_last_of_plane,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [WORD_W-1:0]          cfg_data
);

  vdc_cfg_t    cfg;
  vdc_cmd_t    cmd;
  vdc_status_t status;

  vdc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vdc_dpath #(
    .MAX_TAPS   (MAX_TAPS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .status            (status),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_last_of_plane (out_last_of_plane)
  );

endmodule
